@@ rtl/prefix_function_stream_unit_defines.svh @@
// Assertion helpers for the RTL files; pfs_back includes them.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef PREFIX_FUNCTION_STREAM_UNIT_DEFINES_SVH
`define PREFIX_FUNCTION_STREAM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pfs_pkg.sv @@
`default_nettype none

package pfs_pkg;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } t_in_word;

    typedef struct packed {
        logic [9:0] prefix_len;
        logic       overflow;
    } t_out_word;

    localparam int OUT_LEN_W = 10;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BORDER,
        S_CMP
    } t_state;

endpackage

`default_nettype wire

@@ rtl/pfs_front.sv @@
`default_nettype none

module pfs_front
    import pfs_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire t_in_word                    i_word,
    input  wire logic                        i_q_full,
    output logic                             o_q_push,
    output logic [$clog2(DEPTH)+8:0]         o_q_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);

    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;
    logic [PW-1:0] w_pos_eff;
    logic          w_ovf;

    // start flag rewinds before the word is classified
    assign w_pos_eff = i_word.first ? '0 : r_pos;
    assign w_ovf     = (w_pos_eff == PW'(DEPTH));
    assign n_pos     = w_ovf ? w_pos_eff : w_pos_eff + 1'b1;

    assign full     = i_q_full;
    assign o_q_push = push && !i_q_full;
    assign o_q_data = {w_ovf, w_pos_eff[AW-1:0], i_word.ch};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_q_push) begin
            r_pos <= n_pos;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfs_queue.sv @@
`default_nettype none

module pfs_queue
    import pfs_pkg::*;
#(
    parameter int W = 19
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         w_wr;
    logic         w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfs_back.sv @@
`default_nettype none
`include "prefix_function_stream_unit_defines.svh"

module pfs_back
    import pfs_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_q_valid,
    input  wire logic [$clog2(DEPTH)+8:0] i_q_data,
    output logic                         o_q_pop,
    input  wire logic                    pop,
    output logic                         empty,
    output t_out_word                    o_word
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    char_mem [DEPTH];
    logic [AW-1:0] bord_mem [DEPTH];

    t_state        r_state;
    t_state        n_state;
    logic [7:0]    r_ch;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_bdata;
    logic [7:0]    r_cdata;
    logic          r_out_valid;
    t_out_word     r_out;

    logic [7:0]    q_ch;
    logic [AW-1:0] q_idx;
    logic          q_ovf;

    logic          w_slot_free;
    logic          w_load;
    logic          w_res;
    logic          w_res_ovf;
    logic          w_wr;
    logic [AW-1:0] w_wr_idx;
    logic [7:0]    w_wr_ch;
    logic [AW-1:0] w_jfin;
    logic [AW-1:0] w_bd_addr;
    logic [AW-1:0] w_cd_addr;
    logic          w_match;
    logic [AW+OUT_LEN_W-1:0] w_jx;
    logic          w_out_ovf;

    assign q_ch  = i_q_data[7:0];
    assign q_idx = i_q_data[AW+7:8];
    assign q_ovf = i_q_data[AW+8];

    assign w_slot_free = !r_out_valid || pop;
    assign w_match     = (r_ch == r_cdata);
    assign w_jx        = {{OUT_LEN_W{1'b0}}, w_jfin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        w_load    = 1'b0;
        w_res     = 1'b0;
        w_res_ovf = 1'b0;
        w_wr      = 1'b0;
        w_wr_idx  = r_idx;
        w_wr_ch   = r_ch;
        w_jfin    = '0;
        w_bd_addr = q_idx - 1'b1;
        w_cd_addr = r_j;
        case (r_state)
            S_IDLE: begin
                w_wr_idx = q_idx;
                w_wr_ch  = q_ch;
                if (i_q_valid && w_slot_free) begin
                    o_q_pop = 1'b1;
                    w_load  = 1'b1;
                    if (q_ovf) begin
                        w_res     = 1'b1;
                        w_res_ovf = 1'b1;
                    end else if (q_idx == '0) begin
                        w_res = 1'b1;
                        w_wr  = 1'b1;
                    end else begin
                        n_state = S_BORDER;
                    end
                end
            end
            S_BORDER: begin
                w_cd_addr = r_bdata;
                n_state   = S_CMP;
            end
            S_CMP: begin
                if (w_match || r_j == '0) begin
                    w_jfin = w_match ? AW'(r_j + 1'b1) : '0;
                    if (w_slot_free) begin
                        w_res   = 1'b1;
                        w_wr    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    // fall back to the border of the shorter candidate
                    w_bd_addr = r_j - 1'b1;
                    n_state   = S_BORDER;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            char_mem[w_wr_idx] <= w_wr_ch;
            bord_mem[w_wr_idx] <= w_jfin;
        end
        r_bdata <= bord_mem[w_bd_addr];
        r_cdata <= char_mem[w_cd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ch  <= q_ch;
            r_idx <= q_idx;
        end
        if (r_state == S_BORDER) begin
            r_j <= r_bdata;
        end
        if (w_res) begin
            r_out.prefix_len <= w_jx[OUT_LEN_W-1:0];
            r_out.overflow   <= w_res_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign empty     = !r_out_valid;
    assign o_word    = r_out;
    assign w_out_ovf = r_out_valid && r_out.overflow;

    `PFS_ASSERT_NOW(a_cand_below_idx, r_state == S_CMP, r_j < r_idx, "border not below index")
    `PFS_ASSERT_NOW(a_ovf_len, w_out_ovf, r_out.prefix_len == '0, "overflow word with length")
    `PFS_ASSERT_NEXT(a_idle_hold, r_state == S_IDLE && !i_q_valid, r_state == S_IDLE, "left idle")
    `PFS_ASSERT_NOW(a_res_slot_free, w_res, !r_out_valid || pop, "overwrites unread word")

endmodule

`default_nettype wire

@@ rtl/prefix_function_stream_unit.sv @@
// Streaming KMP prefix-function unit.
// Input queue side: drive i_word {ch, first} and push; a word is taken on a clock
// edge with push high and full low. Set first on the opening byte of each string.
// Result queue side: o_word {prefix_len, overflow} is valid while empty is low and
// is removed on an edge with pop high. Exactly one result per input byte, in order.
// A front stage tracks the string position and tags bytes past MAX_LEN as overflow;
// a two-word queue feeds the back engine, which walks the stored border chain.
// Overflow bytes and a string's first byte are resolved as they leave the queue;
// any other byte passes the border-read and compare states, and each fallback
// step repeats both (two registered-read memory ports walked in turn). The back
// engine takes a new byte from the queue only once the last one is resolved; the
// amortized fallback count per byte is at most one.
// A stalled receiver holds the result register; the engine then stops and the input
// queue fills, so full rises after two further words.
// Reset clears the position and both queues. The byte and border stores are not
// cleared: only entries written earlier in the same string are ever read.
`default_nettype none

module prefix_function_stream_unit
    import pfs_pkg::*;
#(
    parameter int MAX_LEN = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire t_in_word  i_word,
    output logic           empty,
    input  wire logic      pop,
    output t_out_word      o_word
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int QW = AW + 9;

    logic          w_fq_push;
    logic [QW-1:0] w_fq_data;
    logic          w_q_full;
    logic          w_q_valid;
    logic [QW-1:0] w_q_data;
    logic          w_q_pop;

    pfs_front #(
        .DEPTH (MAX_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_word   (i_word),
        .i_q_full (w_q_full),
        .o_q_push (w_fq_push),
        .o_q_data (w_fq_data)
    );

    pfs_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fq_push),
        .i_data  (w_fq_data),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    pfs_back #(
        .DEPTH (MAX_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .pop       (pop),
        .empty     (empty),
        .o_word    (o_word)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import pfs_pkg::*;

    localparam int STR_CAP     = 1024;
    localparam int CYCLE_LIMIT = 500000;
    localparam int QUIET_WORDS = 100;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    t_in_word  i_word = '0;
    logic      full;
    logic      empty;
    t_out_word o_word;

    prefix_function_stream_unit #(
        .MAX_LEN(STR_CAP)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_word (i_word),
        .empty  (empty),
        .pop    (pop),
        .o_word (o_word)
    );

    // predictor state: bytes and borders of the current string
    logic [7:0] kmp_chars [STR_CAP];
    int         kmp_borders [STR_CAP];
    int         kmp_len = 0;

    t_out_word  pending_borders[$];
    t_out_word  want_word;

    bit gaps_on = 1'b1;
    int pop_hold = 0;
    int cycle_cnt = 0;
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int strings_sent = 0;
    int max_border = 0;
    int overflow_seen = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_word kmp_step(input t_in_word w);
        t_out_word r;
        int        j;
        r = '0;
        if (w.first) begin
            kmp_len = 0;
        end
        if (kmp_len >= STR_CAP) begin
            r.overflow = 1'b1;
            return r;
        end
        j = 0;
        if (kmp_len > 0) begin
            j = kmp_borders[kmp_len - 1];
            while (j > 0 && w.ch != kmp_chars[j]) begin
                j = kmp_borders[j - 1];
            end
            if (w.ch == kmp_chars[j]) begin
                j++;
            end
        end
        kmp_chars[kmp_len]   = w.ch;
        kmp_borders[kmp_len] = j;
        kmp_len++;
        r.prefix_len = j[OUT_LEN_W-1:0];
        return r;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endfunction

    // push one word; returns in the step of the edge that took it
    task automatic send_word(input logic [7:0] ch, input logic first);
        t_in_word w;
        w.ch    = ch;
        w.first = first;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        pending_borders.push_back(kmp_step(w));
        words_sent++;
        if (first) begin
            strings_sent++;
        end
    endtask

    // no start flag on the opening byte, byte extremes, fallbacks to zero and
    // to a shorter border, restarts mid-string
    task automatic test_directed();
        logic [7:0] seq_ch [17];
        logic       seq_first [17];
        seq_ch    = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF,
                      8'h61, 8'h61, 8'h62, 8'h61, 8'h61, 8'h61,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
        seq_first = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                      1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        for (int k = 0; k < 17; k++) begin
            send_word(seq_ch[k], seq_first[k]);
        end
    endtask

    // fill a string to capacity with one byte (border climbs to 1023), then
    // overrun it and restart
    task automatic test_overflow();
        logic [7:0] fill;
        fill = 8'($urandom_range(0, 255));
        for (int k = 0; k < STR_CAP; k++) begin
            send_word(fill, k == 0);
        end
        send_word(fill, 1'b0);
        for (int k = 0; k < 5; k++) begin
            send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        send_word(fill, 1'b1);
        send_word(fill, 1'b0);
    endtask

    task automatic test_random_strings(input int n_words);
        int         sent;
        int         len;
        int         mode;
        int         period;
        logic [7:0] sym_a;
        logic [7:0] sym_b;
        logic [7:0] pat [8];
        logic [7:0] ch;
        logic       first;
        sent = 0;
        while (sent < n_words) begin
            mode   = $urandom_range(0, 9);
            len    = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 120)
                                                 : $urandom_range(1, 40);
            period = $urandom_range(1, 8);
            sym_a  = 8'($urandom_range(0, 255));
            sym_b  = 8'($urandom_range(0, 255));
            for (int p = 0; p < 8; p++) begin
                pat[p] = 8'($urandom_range(0, 255));
            end
            for (int k = 0; k < len && sent < n_words; k++) begin
                if (sent >= n_words - QUIET_WORDS) begin
                    gaps_on = 1'b0;
                end
                first = (k == 0);
                if (mode <= 4) begin
                    ch = $urandom_range(0, 1) ? sym_a : sym_b;
                end else if (mode <= 7) begin
                    // periodic with rare breaks to force fallback walks
                    ch = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                      : pat[k % period];
                end else if (mode == 8) begin
                    ch = 8'($urandom_range(0, 255));
                end else begin
                    ch    = $urandom_range(0, 1) ? sym_a : 8'($urandom_range(0, 255));
                    first = ($urandom_range(0, 3) == 0);
                end
                send_word(ch, first);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            words_checked++;
            if (pending_borders.size() == 0) begin
                note_mismatch($sformatf("unexpected result: prefix_len %0d overflow %0b",
                                        o_word.prefix_len, o_word.overflow));
            end else begin
                want_word = pending_borders.pop_front();
                if (o_word.prefix_len != want_word.prefix_len) begin
                    note_mismatch($sformatf("word %0d prefix_len: expected %0d, got %0d",
                                            words_checked, want_word.prefix_len,
                                            o_word.prefix_len));
                end
                if (o_word.overflow != want_word.overflow) begin
                    note_mismatch($sformatf("word %0d overflow: expected %0b, got %0b",
                                            words_checked, want_word.overflow,
                                            o_word.overflow));
                end
            end
            if (int'(o_word.prefix_len) > max_border) begin
                max_border = int'(o_word.prefix_len);
            end
            if (o_word.overflow) begin
                overflow_seen++;
            end
        end
        if (pop_hold > 0) begin
            pop_hold--;
            pop <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 7) == 0) begin
            pop_hold = $urandom_range(1, 9) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_borders.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overflow();
        test_random_strings(550);
        push <= 1'b0;

        while (pending_borders.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("%0d words sent, %0d checked over %0d strings",
                 words_sent, words_checked, strings_sent);
        $display("longest border seen %0d, %0d overflow words, %0d mismatches",
                 max_border, overflow_seen, mismatches);
        if (mismatches == 0 && pending_borders.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/pfs_pkg.sv
rtl/pfs_front.sv
rtl/pfs_queue.sv
rtl/pfs_back.sv
rtl/prefix_function_stream_unit.sv
tb/sv/tb_top.sv
